>>> sv/rhsl_pkg.sv
// rhsl_pkg: shared widths for the rgb to hsl pixel converter
// no dependencies; used by rhsl_front, rhsl_div_pipe and rgb_to_hsl_pixel, not by rhsl_skid
`default_nettype none

package rhsl_pkg;

  // one colour component
  localparam int COMP_W  = 8;
  // lightness is max plus min
  localparam int LIGHT_W = COMP_W + 1;

  typedef logic [COMP_W-1:0]  comp_t;
  typedef logic [LIGHT_W-1:0] light_t;

endpackage

`default_nettype wire

>>> sv/rhsl_front.sv
// rhsl_front: four register stages from rgb to divider operands
// depends on rhsl_pkg for component and lightness widths
`default_nettype none

module rhsl_front #(
  parameter int HUE_FRAC_BITS = 6,
  parameter int SAT_FRAC_BITS = 16
) (
  input  wire                                         clk,
  input  wire                                         rst,
  input  wire                                         en,
  input  wire                                         in_valid,
  input  wire  rhsl_pkg::comp_t                       red,
  input  wire  rhsl_pkg::comp_t                       green,
  input  wire  rhsl_pkg::comp_t                       blue,
  output logic                                        out_valid,
  output rhsl_pkg::light_t                            lightness,
  output logic [HUE_FRAC_BITS+9+rhsl_pkg::COMP_W-1:0] hue_num,
  output rhsl_pkg::comp_t                             hue_den,
  output logic [SAT_FRAC_BITS+rhsl_pkg::COMP_W-1:0]   sat_num,
  output rhsl_pkg::comp_t                             sat_den
);

  localparam int HNW    = HUE_FRAC_BITS + 9 + rhsl_pkg::COMP_W;
  localparam int SNW    = SAT_FRAC_BITS + rhsl_pkg::COMP_W;
  localparam int UNIT   = 60 * (1 << HUE_FRAC_BITS);
  // sextant numerator stays below 6 * 255
  localparam int SEC_W  = rhsl_pkg::COMP_W + 3;

  typedef enum logic [1:0] {SEL_RED, SEL_GREEN, SEL_BLUE} sel_t;

  // stage 1: input word
  logic            v1;
  rhsl_pkg::comp_t r1, g1, b1;
  // stage 2: extremes and which component leads
  logic            v2;
  rhsl_pkg::comp_t r2, g2, b2, mx2, mn2;
  sel_t            sel2;
  // stage 3: spread, sum, divisor, sextant numerator
  logic            v3;
  rhsl_pkg::comp_t d3, den3;
  rhsl_pkg::light_t sum3;
  logic [SEC_W-1:0] sec3;

  rhsl_pkg::comp_t  mx_next, mn_next;
  sel_t             sel_next;
  rhsl_pkg::comp_t  d_next, den_next;
  rhsl_pkg::light_t sum_next;
  logic [SEC_W-1:0] sec_next, d_ext, six_d;

  always_comb begin
    mx_next  = r1;
    mn_next  = r1;
    sel_next = SEL_RED;
    if (g1 > mx_next) begin
      mx_next  = g1;
      sel_next = SEL_GREEN;
    end
    if (b1 > mx_next) begin
      mx_next  = b1;
      sel_next = SEL_BLUE;
    end
    if (g1 < mn_next) mn_next = g1;
    if (b1 < mn_next) mn_next = b1;
  end

  always_comb begin
    d_next   = mx2 - mn2;
    sum_next = {1'b0, mx2} + {1'b0, mn2};
    d_ext    = SEC_W'(d_next);
    six_d    = (d_ext << 2) + (d_ext << 1);
    // grey pixel: divisor forced to one so both quotients come out zero
    if (d_next == '0) begin
      den_next = rhsl_pkg::comp_t'(1);
    end else if (sum_next <= rhsl_pkg::light_t'(255)) begin
      den_next = sum_next[rhsl_pkg::COMP_W-1:0];
    end else begin
      den_next = rhsl_pkg::comp_t'(rhsl_pkg::light_t'(510) - sum_next);
    end
    // negative hue wraps by a full turn, i.e. six spreads
    case (sel2)
      SEL_RED: begin
        sec_next = SEC_W'(g2) - SEC_W'(b2) + ((g2 < b2) ? six_d : '0);
      end
      SEL_GREEN: begin
        sec_next = (d_ext << 1) + SEC_W'(b2) - SEC_W'(r2);
      end
      default: begin
        sec_next = (d_ext << 2) + SEC_W'(r2) - SEC_W'(g2);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1        <= red;
      g1        <= green;
      b1        <= blue;
      r2        <= r1;
      g2        <= g1;
      b2        <= b1;
      mx2       <= mx_next;
      mn2       <= mn_next;
      sel2      <= sel_next;
      d3        <= d_next;
      den3      <= den_next;
      sum3      <= sum_next;
      sec3      <= sec_next;
      lightness <= sum3;
      hue_num   <= HNW'(UNIT) * HNW'(sec3);
      hue_den   <= (d3 == '0) ? rhsl_pkg::comp_t'(1) : d3;
      sat_num   <= SNW'(d3) << SAT_FRAC_BITS;
      sat_den   <= den3;
    end
  end

endmodule

`default_nettype wire

>>> sv/rhsl_div_pipe.sv
// rhsl_div_pipe: pipelined restoring divider, one quotient bit per stage after the delay-only leading stages
// depends on rhsl_pkg for the divisor width; quotient must fit in QW bits
`default_nettype none

module rhsl_div_pipe #(
  parameter int NW     = 24,
  parameter int QW     = 17,
  parameter int STAGES = 17
) (
  input  wire                   clk,
  input  wire                   en,
  input  wire  [NW-1:0]         num,
  input  wire  rhsl_pkg::comp_t den,
  output logic [QW-1:0]         quo
);

  localparam int DW   = rhsl_pkg::COMP_W;
  // leading stages only delay, so quotients of different widths line up
  localparam int PASS = STAGES - QW;

  // partial remainder stays below the divisor
  logic [DW-1:0] rem   [STAGES+1];
  // numerator bits still to bring down, quotient bits shifted in below
  logic [QW-1:0] acc   [STAGES+1];
  logic [DW-1:0] den_p [STAGES+1];

  assign rem[0]   = DW'(num >> QW);
  assign acc[0]   = num[QW-1:0];
  assign den_p[0] = den;

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    if (k < PASS) begin : g_pass
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1]   <= rem[k];
          acc[k+1]   <= acc[k];
          den_p[k+1] <= den_p[k];
        end
      end
    end else begin : g_step
      logic [DW:0] trial, diff;
      logic        fits;
      assign trial = {rem[k], acc[k][QW-1]};
      assign diff  = trial - {1'b0, den_p[k]};
      assign fits  = trial >= {1'b0, den_p[k]};
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1]   <= fits ? diff[DW-1:0] : trial[DW-1:0];
          acc[k+1]   <= {acc[k][QW-2:0], fits};
          den_p[k+1] <= den_p[k];
        end
      end
    end
  end

  assign quo = acc[STAGES];

endmodule

`default_nettype wire

>>> sv/rhsl_skid.sv
// rhsl_skid: output register with a skid word, cuts the tready path
// no package dependencies
`default_nettype none

module rhsl_skid #(
  parameter int W = 48
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          in_valid,
  output logic         in_ready,
  input  wire  [W-1:0] in_data,
  output logic         out_valid,
  input  wire          out_ready,
  output logic [W-1:0] out_data
);

  logic         skid_valid;
  logic [W-1:0] skid_data;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
        out_data  <= in_data;
      end
    end else if (in_valid && !skid_valid) begin
      // output word held, park the incoming one
      skid_valid <= 1'b1;
      skid_data  <= in_data;
    end
  end

endmodule

`default_nettype wire

>>> sv/rgb_to_hsl_pixel.sv
// rgb_to_hsl_pixel: 8-bit rgb pixel to hue, saturation and lightness
// pixel path: four operand stages, then the two dividers, each one stage deep per quotient bit of
// the wider quotient, the hue divider delaying its narrower quotient to match, then one output register
// throughput one pixel per cycle; a stalled output freezes the whole pipeline
// reset clears valid bits only; no state survives between pixels
// depends on rhsl_pkg, rhsl_front, rhsl_div_pipe and rhsl_skid
`default_nettype none

module rgb_to_hsl_pixel #(
  parameter int HUE_FRAC_BITS = 6,
  parameter int SAT_FRAC_BITS = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  // red [7:0], green [15:8], blue [23:16]
  input  wire  [23:0] s_tdata,
  output logic        m_tvalid,
  input  wire         m_tready,
  // hue, saturation, lightness from bit 0 up, zero padded to bytes
  output logic [((HUE_FRAC_BITS + 9 + SAT_FRAC_BITS + 1 + rhsl_pkg::LIGHT_W + 7) / 8) * 8 - 1:0]
               m_tdata
);

  localparam int HUE_W  = HUE_FRAC_BITS + 9;
  localparam int SAT_W  = SAT_FRAC_BITS + 1;
  localparam int HNW    = HUE_W + rhsl_pkg::COMP_W;
  localparam int SNW    = SAT_FRAC_BITS + rhsl_pkg::COMP_W;
  localparam int STAGES = (SAT_W > HUE_W) ? SAT_W : HUE_W;
  localparam int RES_W  = HUE_W + SAT_W + rhsl_pkg::LIGHT_W;
  localparam int OUT_W  = ((RES_W + 7) / 8) * 8;

  logic             en;
  logic             f_valid;
  rhsl_pkg::light_t f_light;
  logic [HNW-1:0]   f_hue_num;
  rhsl_pkg::comp_t  f_hue_den;
  logic [SNW-1:0]   f_sat_num;
  rhsl_pkg::comp_t  f_sat_den;
  logic [HUE_W-1:0] hue;
  logic [SAT_W-1:0] saturation;

  // valid and lightness ride alongside the dividers
  logic             vld_d   [STAGES+1];
  rhsl_pkg::light_t light_d [STAGES+1];

  assign s_tready = en;

  rhsl_front #(
    .HUE_FRAC_BITS (HUE_FRAC_BITS),
    .SAT_FRAC_BITS (SAT_FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .red       (s_tdata[7:0]),
    .green     (s_tdata[15:8]),
    .blue      (s_tdata[23:16]),
    .out_valid (f_valid),
    .lightness (f_light),
    .hue_num   (f_hue_num),
    .hue_den   (f_hue_den),
    .sat_num   (f_sat_num),
    .sat_den   (f_sat_den)
  );

  rhsl_div_pipe #(
    .NW     (HNW),
    .QW     (HUE_W),
    .STAGES (STAGES)
  ) u_hue_div (
    .clk (clk),
    .en  (en),
    .num (f_hue_num),
    .den (f_hue_den),
    .quo (hue)
  );

  rhsl_div_pipe #(
    .NW     (SNW),
    .QW     (SAT_W),
    .STAGES (STAGES)
  ) u_sat_div (
    .clk (clk),
    .en  (en),
    .num (f_sat_num),
    .den (f_sat_den),
    .quo (saturation)
  );

  assign vld_d[0]   = f_valid;
  assign light_d[0] = f_light;

  for (genvar k = 0; k < STAGES; k++) begin : g_delay
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_d[k+1] <= 1'b0;
      end else if (en) begin
        vld_d[k+1] <= vld_d[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        light_d[k+1] <= light_d[k];
      end
    end
  end

  rhsl_skid #(
    .W (OUT_W)
  ) u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld_d[STAGES]),
    .in_ready  (en),
    .in_data   (OUT_W'({light_d[STAGES], saturation, hue})),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

`default_nettype wire
